>>> rtl/sbsr_pkg.sv
// Package for the bounding-sphere ratio pipeline: widths, shape codes,
// stage payload types. No dependencies.
`timescale 1ns / 1ps
package sbsr_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int DIM_W      = 32;
   localparam int MAG_W      = DIM_W + 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int ROOT_W     = 34;
   localparam int RT_W       = 2 * ROOT_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = DIM_W;
   localparam int SHIFT_W    = DIM_W - FRAC_BITS;

   localparam logic [DIM_W-1:0] ONE_FIX   = DIM_W'(1) << FRAC_BITS;
   localparam logic [DIM_W-1:0] BOUND_MAX = {1'b0, {(DIM_W-1){1'b1}}};
   localparam logic [DIM_W-1:0] RATIO_MAX = '1;

   typedef enum logic [1:0] {
      SHAPE_SPHERE  = 2'd0,
      SHAPE_BOX     = 2'd1,
      SHAPE_CAPSULE = 2'd2,
      SHAPE_OTHER   = 2'd3
   } shape_type;

   typedef struct packed {
      logic             is_sphere;
      logic             use_root;
      logic             div_ok;
      logic [DIM_W-1:0] val;
   } side_type;

   typedef struct packed {
      logic [MAG_W-1:0] m0;
      logic [MAG_W-1:0] m1;
      logic [MAG_W-1:0] m2;
      side_type         side;
   } prep_type;

   typedef struct packed {
      logic [SQ_W-1:0] s0;
      logic [SQ_W-1:0] s1;
      logic [SQ_W-1:0] s2;
      side_type        side;
   } prod_type;

   typedef struct packed {
      logic [RT_W-1:0] op;
      logic [RT_W-1:0] res;
      side_type        side;
   } root_type;

   typedef struct packed {
      logic [ROOT_W-1:0] cr;
      logic              sat;
      logic [DIM_W-1:0]  rem;
      logic [DIM_W-1:0]  quo;
      side_type          side;
   } div_type;

   function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
      mag = v[MAG_W-1] ? MAG_W'(-v) : v;
   endfunction
endpackage

>>> rtl/shape_bounding_sphere_ratio_core.sv
// Bounding-sphere radius and circum/in radius ratio, fully pipelined.
// Stages in order: prep, square, sum, one square-root bit per stage,
// saturation check, one quotient bit per stage, output register.
// Throughput one beat per cycle; the whole pipe holds while the output beat stalls.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Depends on sbsr_pkg.
`timescale 1ns / 1ps
module shape_bounding_sphere_ratio_core
   import sbsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_shape_kind,
   input  logic signed [31:0] req_dim_a,
   input  logic signed [31:0] req_dim_b,
   input  logic signed [31:0] req_dim_c,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [31:0] rsp_bound_radius,
   output logic [31:0]       rsp_radius_ratio
);
   logic adv;

   logic     p1_vld_ff, p2_vld_ff, p3_vld_ff, dv0_vld_ff, rsp_vld_ff;
   prep_type p1_ff, p1_in;
   prod_type p2_ff, p2_in;
   logic [SQ_W-1:0] sum_ff, sum_in;
   side_type        p3_side_ff;

   logic [SQRT_STEPS-1:0] sq_vld_ff;
   root_type sq_ff [SQRT_STEPS];
   root_type sq_in [SQRT_STEPS];

   div_type  dv0_ff, dv0_in;
   logic [DIV_STEPS-1:0] dv_vld_ff;
   div_type  dv_ff [DIV_STEPS];
   div_type  dv_in [DIV_STEPS];

   logic [DIM_W-1:0] bound_ff, bound_in, ratio_ff, ratio_in;

   assign adv       = !rsp_vld_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_bound_radius = bound_ff;
   assign rsp_radius_ratio = ratio_ff;

   // prep: magnitudes, capsule sum, smallest extent
   always_comb begin
      logic signed [MAG_W-1:0] sa, sb, sc, ssum;
      logic signed [DIM_W-1:0] mn;
      sa   = MAG_W'(req_dim_a);
      sb   = MAG_W'(req_dim_b);
      sc   = MAG_W'(req_dim_c);
      ssum = sa + sb;
      mn   = req_dim_a;
      if (req_dim_b < mn) mn = req_dim_b;
      if (req_dim_c < mn) mn = req_dim_c;
      p1_in = '0;
      unique case (shape_type'(req_shape_kind))
         SHAPE_SPHERE: begin
            p1_in.side.is_sphere = 1'b1;
            p1_in.side.val       = req_dim_a;
         end
         SHAPE_BOX: begin
            p1_in.m0            = mag(sa);
            p1_in.m1            = mag(sb);
            p1_in.m2            = mag(sc);
            p1_in.side.use_root = 1'b1;
            p1_in.side.div_ok   = mn > 0;
            p1_in.side.val      = mn;
         end
         SHAPE_CAPSULE: begin
            if (req_dim_a > 0) begin
               p1_in.m0            = mag(sa);
               p1_in.m1            = mag(ssum);
               p1_in.side.use_root = 1'b1;
               p1_in.side.div_ok   = 1'b1;
               p1_in.side.val      = req_dim_a;
            end
         end
         SHAPE_OTHER: begin
            p1_in = '0;
         end
         default: p1_in = '0;
      endcase
   end

   always_comb begin
      p2_in.s0   = SQ_W'(p1_ff.m0) * SQ_W'(p1_ff.m0);
      p2_in.s1   = SQ_W'(p1_ff.m1) * SQ_W'(p1_ff.m1);
      p2_in.s2   = SQ_W'(p1_ff.m2) * SQ_W'(p1_ff.m2);
      p2_in.side = p1_ff.side;
      sum_in     = p2_ff.s0 + p2_ff.s1 + p2_ff.s2;
   end

   // square root: two radicand bits per stage
   always_comb begin
      root_type cur;
      logic [RT_W-1:0] one_c, trial;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         if (i == 0) begin
            cur.op   = RT_W'(sum_ff);
            cur.res  = '0;
            cur.side = p3_side_ff;
         end else begin
            cur = sq_ff[i-1];
         end
         one_c = RT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
         trial = cur.res + one_c;
         if (cur.op >= trial) begin
            sq_in[i].op  = cur.op - trial;
            sq_in[i].res = (cur.res >> 1) + one_c;
         end else begin
            sq_in[i].op  = cur.op;
            sq_in[i].res = cur.res >> 1;
         end
         sq_in[i].side = cur.side;
      end
   end

   always_comb begin
      logic [ROOT_W-1:0] cr;
      cr          = sq_ff[SQRT_STEPS-1].res[ROOT_W-1:0];
      dv0_in.cr   = cr;
      dv0_in.side = sq_ff[SQRT_STEPS-1].side;
      dv0_in.sat  = (2*RT_W)'(cr) >=
                    ((2*RT_W)'(sq_ff[SQRT_STEPS-1].side.val[DIM_W-2:0]) << SHIFT_W);
      dv0_in.rem  = DIM_W'(cr >> SHIFT_W);
      dv0_in.quo  = '0;
   end

   // division: one quotient bit per stage
   always_comb begin
      div_type cur;
      logic nb;
      logic [DIM_W-1:0] t, d;
      for (int j = 0; j < DIV_STEPS; j++) begin
         cur = (j == 0) ? dv0_ff : dv_ff[(j == 0) ? 0 : j-1];
         if (DIV_STEPS - 1 - j >= FRAC_BITS)
            nb = cur.cr[(DIV_STEPS - 1 - j >= FRAC_BITS) ? (DIV_STEPS - 1 - j - FRAC_BITS) : 0];
         else
            nb = 1'b0;
         d = {1'b0, cur.side.val[DIM_W-2:0]};
         t = {cur.rem[DIM_W-2:0], nb};
         dv_in[j] = cur;
         if (t >= d) begin
            dv_in[j].rem = t - d;
            dv_in[j].quo = {cur.quo[DIM_W-2:0], 1'b1};
         end else begin
            dv_in[j].rem = t;
            dv_in[j].quo = {cur.quo[DIM_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      div_type f;
      f = dv_ff[DIV_STEPS-1];
      bound_in = '0;
      ratio_in = '0;
      if (f.side.is_sphere) begin
         bound_in = f.side.val;
         ratio_in = ($signed(f.side.val) > 0) ? ONE_FIX : '0;
      end else if (f.side.use_root) begin
         bound_in = (f.cr > ROOT_W'(BOUND_MAX)) ? BOUND_MAX : DIM_W'(f.cr);
         if (f.side.div_ok)
            ratio_in = f.sat ? RATIO_MAX : f.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         sq_vld_ff  <= '0;
         dv0_vld_ff <= 1'b0;
         dv_vld_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff  <= req_valid;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         sq_vld_ff  <= {sq_vld_ff[SQRT_STEPS-2:0], p3_vld_ff};
         dv0_vld_ff <= sq_vld_ff[SQRT_STEPS-1];
         dv_vld_ff  <= {dv_vld_ff[DIV_STEPS-2:0], dv0_vld_ff};
         rsp_vld_ff <= dv_vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         sum_ff     <= sum_in;
         p3_side_ff <= p2_ff.side;
         for (int i = 0; i < SQRT_STEPS; i++) sq_ff[i] <= sq_in[i];
         dv0_ff     <= dv0_in;
         for (int j = 0; j < DIV_STEPS; j++) dv_ff[j] <= dv_in[j];
         bound_ff   <= bound_in;
         ratio_ff   <= ratio_in;
      end
   end

   a_nonpos_no_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && ($signed(bound_ff) <= 0) |-> (ratio_ff == '0))
      else $error("ratio nonzero with non-positive bound");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sq_vld_ff) && $stable(dv_vld_ff))
      else $error("pipe advanced while output held");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQRT_STEPS-1] |->
         (sq_ff[SQRT_STEPS-1].op <= {sq_ff[SQRT_STEPS-1].res[RT_W-2:0], 1'b0}))
      else $error("root remainder out of range");
endmodule

>>> tb/tb_shape_bounding_sphere_ratio_checker.sv
// Checker for the bounding-sphere ratio core: watches both channels, predicts
// each beat's radius and ratio, and compares in order. Depends on sbsr_pkg.
`timescale 1ns / 1ps
module tb_shape_bounding_sphere_ratio_checker
   import sbsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_shape_kind,
   input  logic signed [31:0] req_dim_a,
   input  logic signed [31:0] req_dim_b,
   input  logic signed [31:0] req_dim_c,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic signed [31:0] rsp_bound_radius,
   input  logic [31:0]       rsp_radius_ratio,
   output int                fail_count,
   output int                pending
);
   typedef struct {
      logic [31:0] bound;
      logic [31:0] ratio;
   } fit_type;

   fit_type fit_q[$];

   function automatic logic [33:0] floor_root(input logic [67:0] n);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         if ({34'd0, c} * {34'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp_ratio(input logic [33:0] root,
                                               input logic [31:0] inner);
      logic [63:0] q;
      q = ({30'd0, root} << FRAC_BITS) / {32'd0, inner};
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic fit_type fit_shape(input shape_type kind,
                                         input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c);
      fit_type f;
      logic signed [67:0] ea, eb, ec, inner, s;
      logic [67:0] sum;
      logic [33:0] root;
      ea = 68'(a); eb = 68'(b); ec = 68'(c);
      f.bound = '0;
      f.ratio = '0;
      case (kind)
         SHAPE_SPHERE: begin
            f.bound = a;
            f.ratio = (a > 0) ? ONE_FIX : '0;
         end
         SHAPE_BOX: begin
            sum = ea * ea + eb * eb + ec * ec;
            root = floor_root(sum);
            inner = ea;
            if (eb < inner) inner = eb;
            if (ec < inner) inner = ec;
            f.bound = (root > 34'h7FFF_FFFF) ? BOUND_MAX : root[31:0];
            if (inner > 0) f.ratio = clamp_ratio(root, inner[31:0]);
         end
         SHAPE_CAPSULE: begin
            if (a > 0) begin
               s = ea + eb;
               sum = s * s + ea * ea;
               root = floor_root(sum);
               f.bound = (root > 34'h7FFF_FFFF) ? BOUND_MAX : root[31:0];
               f.ratio = clamp_ratio(root, a);
            end
         end
         default: ;
      endcase
      return f;
   endfunction

   always @(posedge clock) begin
      fit_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            fit_q.push_back(fit_shape(shape_type'(req_shape_kind),
                                      req_dim_a, req_dim_b, req_dim_c));
         if (rsp_valid && !rsp_stall) begin
            if (fit_q.size() == 0) begin
               $error("unexpected beat: bound_radius %h radius_ratio %h",
                      rsp_bound_radius, rsp_radius_ratio);
               errs++;
            end else begin
               want = fit_q.pop_front();
               if (rsp_bound_radius !== want.bound) begin
                  $error("bound_radius expected %h actual %h", want.bound,
                         rsp_bound_radius);
                  errs++;
               end
               if (rsp_radius_ratio !== want.ratio) begin
                  $error("radius_ratio expected %h actual %h", want.ratio,
                         rsp_radius_ratio);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= fit_q.size();
   end
endmodule

>>> tb/tb_shape_bounding_sphere_ratio_core.sv
// Testbench top for the bounding-sphere ratio core: directed and random
// shapes with bursty sender and stalling receiver. Depends on sbsr_pkg and the checker.
`timescale 1ns / 1ps
module tb_shape_bounding_sphere_ratio_core;
   import sbsr_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_shape_kind = '0;
   logic signed [31:0] req_dim_a = '0;
   logic signed [31:0] req_dim_b = '0;
   logic signed [31:0] req_dim_c = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [31:0] rsp_bound_radius;
   logic [31:0]       rsp_radius_ratio;
   int                fail_count;
   int                pending;
   logic              stall_on = 1'b0;

   always #10 clock = ~clock;

   shape_bounding_sphere_ratio_core u_top (.*);

   tb_shape_bounding_sphere_ratio_checker u_chk (.*);

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return $urandom_range(1, 8) << 16;
         4: return -($urandom_range(0, 300000));
         5: return $urandom_range(0, 2000000);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_beat(input shape_type kind, input logic [31:0] a,
                            input logic [31:0] b, input logic [31:0] c);
      req_valid      <= 1'b1;
      req_shape_kind <= kind;
      req_dim_a      <= a;
      req_dim_b      <= b;
      req_dim_c      <= c;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver stall pattern: long free stretches alternate with stall runs.
   always @(posedge clock) begin
      if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
      rsp_stall <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b0;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [31:0] edges [6];
      int burst;
      int waited;
      edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 6; i++)
            send_beat(shape_type'(k), edges[i], edges[5 - i], edges[(i + 2) % 6]);
      send_beat(SHAPE_BOX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(SHAPE_CAPSULE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      send_beat(SHAPE_BOX, 32'h0003_0000, 32'h0004_0000, 32'h0);
      for (int n = 0; n < 1800; n += burst) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst; j++)
            send_beat(shape_type'($urandom_range(0, 3)), pick_dim(), pick_dim(),
                      pick_dim());
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(posedge clock);
      end
      req_valid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
